// ----- src/rth_pkg.sv -----
// Package for the 8-bit RGB to HSV converter.
// Holds field widths, scaling constants, sector codes and the interstage struct.
// No dependencies.
package rth_pkg;

    localparam int DATA_W    = 8;
    localparam int NUM_W     = 16;
    localparam int DIV_STEPS = 8;

    localparam logic [DATA_W-1:0] HUE_SPAN   = 8'd43;
    localparam logic [DATA_W-1:0] GREEN_BASE = 8'd85;
    localparam logic [DATA_W-1:0] BLUE_BASE  = 8'd171;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

    typedef struct packed {
        logic              grey;
        logic              neg;
        sector_t           sector;
        logic [DATA_W-1:0] val;
    } side_t;

endpackage

// ----- src/rth_front.sv -----
// Front end of the converter: channel maximum, minimum, sector and hue difference,
// then the two dividend products. Two register stages. Depends on rth_pkg.
module rth_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [rth_pkg::DATA_W-1:0]  red,
    input  logic [rth_pkg::DATA_W-1:0]  green,
    input  logic [rth_pkg::DATA_W-1:0]  blue,
    output logic                        out_valid,
    output rth_pkg::side_t              out_side,
    output logic [rth_pkg::NUM_W-1:0]   sat_num,
    output logic [rth_pkg::DATA_W-1:0]  sat_den,
    output logic [rth_pkg::NUM_W-1:0]   hue_num,
    output logic [rth_pkg::DATA_W-1:0]  hue_den
);

    logic                       s1_valid_reg;
    logic [rth_pkg::DATA_W-1:0] s1_hi_reg, s1_hi_next;
    logic [rth_pkg::DATA_W-1:0] s1_delta_reg, s1_delta_next;
    logic [rth_pkg::DATA_W-1:0] s1_abs_reg, s1_abs_next;
    logic                       s1_neg_reg, s1_neg_next;
    rth_pkg::sector_t           s1_sector_reg, s1_sector_next;

    logic                       s2_valid_reg;
    rth_pkg::side_t             s2_side_reg, s2_side_next;
    logic [rth_pkg::NUM_W-1:0]  s2_sat_num_reg, s2_sat_num_next;
    logic [rth_pkg::DATA_W-1:0] s2_sat_den_reg;
    logic [rth_pkg::NUM_W-1:0]  s2_hue_num_reg, s2_hue_num_next;
    logic [rth_pkg::DATA_W-1:0] s2_hue_den_reg;

    logic [rth_pkg::DATA_W-1:0] lo;
    logic [rth_pkg::DATA_W:0]   diff;

    always_comb begin
        if (red >= green && red >= blue) begin
            s1_sector_next = rth_pkg::SEC_RED;
            s1_hi_next     = red;
            lo             = (green < blue) ? green : blue;
            diff           = {1'b0, green} - {1'b0, blue};
        end else if (green >= blue) begin
            s1_sector_next = rth_pkg::SEC_GREEN;
            s1_hi_next     = green;
            lo             = (red < blue) ? red : blue;
            diff           = {1'b0, blue} - {1'b0, red};
        end else begin
            s1_sector_next = rth_pkg::SEC_BLUE;
            s1_hi_next     = blue;
            lo             = (red < green) ? red : green;
            diff           = {1'b0, red} - {1'b0, green};
        end
        s1_delta_next = s1_hi_next - lo;
        s1_neg_next   = diff[rth_pkg::DATA_W];
        s1_abs_next   = s1_neg_next ? rth_pkg::DATA_W'(-diff)
                                    : diff[rth_pkg::DATA_W-1:0];
    end

    always_comb begin
        s2_sat_num_next    = ({s1_delta_reg, 8'd0}) - {8'd0, s1_delta_reg};
        s2_hue_num_next    = rth_pkg::NUM_W'({8'd0, s1_abs_reg} * {8'd0, rth_pkg::HUE_SPAN});
        s2_side_next.grey   = (s1_delta_reg == '0);
        s2_side_next.neg    = s1_neg_reg;
        s2_side_next.sector = s1_sector_reg;
        s2_side_next.val    = s1_hi_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_hi_reg      <= s1_hi_next;
            s1_delta_reg   <= s1_delta_next;
            s1_abs_reg     <= s1_abs_next;
            s1_neg_reg     <= s1_neg_next;
            s1_sector_reg  <= s1_sector_next;
            s2_side_reg    <= s2_side_next;
            s2_sat_num_reg <= s2_sat_num_next;
            s2_sat_den_reg <= s1_hi_reg;
            s2_hue_num_reg <= s2_hue_num_next;
            s2_hue_den_reg <= s1_delta_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_side  = s2_side_reg;
    assign sat_num   = s2_sat_num_reg;
    assign sat_den   = s2_sat_den_reg;
    assign hue_num   = s2_hue_num_reg;
    assign hue_den   = s2_hue_den_reg;

endmodule

// ----- src/rth_div.sv -----
// Pipelined restoring divider with two lanes, one quotient bit per stage.
// Carries the pixel side information alongside. Depends on rth_pkg.
module rth_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  rth_pkg::side_t              in_side,
    input  logic [rth_pkg::NUM_W-1:0]   sat_num,
    input  logic [rth_pkg::DATA_W-1:0]  sat_den,
    input  logic [rth_pkg::NUM_W-1:0]   hue_num,
    input  logic [rth_pkg::DATA_W-1:0]  hue_den,
    output logic                        out_valid,
    output rth_pkg::side_t              out_side,
    output logic [rth_pkg::DATA_W-1:0]  sat_quo,
    output logic [rth_pkg::DATA_W-1:0]  hue_quo
);

    localparam int N = rth_pkg::DIV_STEPS;
    localparam int W = rth_pkg::NUM_W;
    localparam int D = rth_pkg::DATA_W;

    logic           valid_reg   [N];
    rth_pkg::side_t side_reg    [N];
    logic [W-1:0]   sat_rem_reg [N];
    logic [D-1:0]   sat_den_reg [N];
    logic [N-1:0]   sat_quo_reg [N];
    logic [W-1:0]   hue_rem_reg [N];
    logic [D-1:0]   hue_den_reg [N];
    logic [N-1:0]   hue_quo_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam int SH = N - 1 - k;

        logic           valid_in;
        rth_pkg::side_t side_in;
        logic [W-1:0]   sat_rem_in, hue_rem_in;
        logic [D-1:0]   sat_den_in, hue_den_in;
        logic [N-1:0]   sat_quo_in, hue_quo_in;
        logic [W-1:0]   sat_sub, hue_sub;
        logic           sat_bit, hue_bit;

        if (k == 0) begin : g_first
            assign valid_in   = in_valid;
            assign side_in    = in_side;
            assign sat_rem_in = sat_num;
            assign sat_den_in = sat_den;
            assign sat_quo_in = '0;
            assign hue_rem_in = hue_num;
            assign hue_den_in = hue_den;
            assign hue_quo_in = '0;
        end else begin : g_rest
            assign valid_in   = valid_reg[k-1];
            assign side_in    = side_reg[k-1];
            assign sat_rem_in = sat_rem_reg[k-1];
            assign sat_den_in = sat_den_reg[k-1];
            assign sat_quo_in = sat_quo_reg[k-1];
            assign hue_rem_in = hue_rem_reg[k-1];
            assign hue_den_in = hue_den_reg[k-1];
            assign hue_quo_in = hue_quo_reg[k-1];
        end

        assign sat_sub = W'(sat_den_in) << SH;
        assign hue_sub = W'(hue_den_in) << SH;
        assign sat_bit = (sat_rem_in >= sat_sub);
        assign hue_bit = (hue_rem_in >= hue_sub);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k]    <= side_in;
                sat_den_reg[k] <= sat_den_in;
                hue_den_reg[k] <= hue_den_in;
                sat_rem_reg[k] <= sat_bit ? (sat_rem_in - sat_sub) : sat_rem_in;
                hue_rem_reg[k] <= hue_bit ? (hue_rem_in - hue_sub) : hue_rem_in;
                sat_quo_reg[k] <= {sat_quo_in[N-2:0], sat_bit};
                hue_quo_reg[k] <= {hue_quo_in[N-2:0], hue_bit};
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign sat_quo   = D'(sat_quo_reg[N-1]);
    assign hue_quo   = D'(hue_quo_reg[N-1]);

endmodule

// ----- src/rth_back.sv -----
// Converter back end: adds the signed hue quotient to the sector offset and
// holds the result transaction in the output register. Depends on rth_pkg.
module rth_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  rth_pkg::side_t              in_side,
    input  logic [rth_pkg::DATA_W-1:0]  sat_quo,
    input  logic [rth_pkg::DATA_W-1:0]  hue_quo,
    output logic                        out_valid,
    output logic [rth_pkg::DATA_W-1:0]  hue,
    output logic [rth_pkg::DATA_W-1:0]  sat,
    output logic [rth_pkg::DATA_W-1:0]  val
);

    logic                       valid_reg;
    logic [rth_pkg::DATA_W-1:0] hue_reg, hue_next;
    logic [rth_pkg::DATA_W-1:0] sat_reg, sat_next;
    logic [rth_pkg::DATA_W-1:0] val_reg;
    logic [rth_pkg::DATA_W-1:0] base;

    always_comb begin
        case (in_side.sector)
            rth_pkg::SEC_RED:   base = '0;
            rth_pkg::SEC_GREEN: base = rth_pkg::GREEN_BASE;
            rth_pkg::SEC_BLUE:  base = rth_pkg::BLUE_BASE;
            default:            base = '0;
        endcase
        if (in_side.grey) begin
            hue_next = '0;
            sat_next = '0;
        end else begin
            hue_next = in_side.neg ? (base - hue_quo) : (base + hue_quo);
            sat_next = sat_quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= in_side.val;
        end
    end

    assign out_valid = valid_reg;
    assign hue       = hue_reg;
    assign sat       = sat_reg;
    assign val       = val_reg;

endmodule

// ----- src/rgb_to_hsv_8bit_core.sv -----
// Top level of the 8-bit RGB to HSV converter.
// Instantiates rth_front, rth_div and rth_back; depends on rth_pkg.
//
// Channel   Direction  Payload (tdata, lowest bit first)
// s_        input      red_in[7:0], green_in[15:8], blue_in[23:16]
// m_        output     hue_out[7:0], sat_out[15:8], val_out[23:16]
//
// One transaction is accepted per cycle while the pipeline advances, and each produces
// one result after two front stages, eight divider stages and the output register.
// The whole pipeline advances when the output register is empty or being read.
// A stall on m_tready holds every stage, so nothing is lost or repeated.
// Reset clears all valid bits.
module rgb_to_hsv_8bit_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // hue_out, sat_out, val_out
);

    logic                       en;
    logic                       front_valid, div_valid;
    rth_pkg::side_t             front_side, div_side;
    logic [rth_pkg::NUM_W-1:0]  sat_num, hue_num;
    logic [rth_pkg::DATA_W-1:0] sat_den, hue_den, sat_quo, hue_quo;
    logic [rth_pkg::DATA_W-1:0] hue_out, sat_out, val_out;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    rth_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .out_valid (front_valid),
        .out_side  (front_side),
        .sat_num   (sat_num),
        .sat_den   (sat_den),
        .hue_num   (hue_num),
        .hue_den   (hue_den)
    );

    rth_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .in_side   (front_side),
        .sat_num   (sat_num),
        .sat_den   (sat_den),
        .hue_num   (hue_num),
        .hue_den   (hue_den),
        .out_valid (div_valid),
        .out_side  (div_side),
        .sat_quo   (sat_quo),
        .hue_quo   (hue_quo)
    );

    rth_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_valid),
        .in_side   (div_side),
        .sat_quo   (sat_quo),
        .hue_quo   (hue_quo),
        .out_valid (m_tvalid),
        .hue       (hue_out),
        .sat       (sat_out),
        .val       (val_out)
    );

    assign m_tdata = {val_out, sat_out, hue_out};

endmodule

// ----- tb/rgb_to_hsv_8bit_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rgb_to_hsv_8bit_core: streams RGB pixels in and checks each
// HSV result against an in-bench conversion. Depends on rth_pkg and the converter RTL.
module rgb_to_hsv_8bit_core_tb;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int RANDOM_PIXELS   = 1450;
    localparam int DRAIN_CYCLES    = 20;

    typedef struct packed {
        logic [7:0] val;
        logic [7:0] sat;
        logic [7:0] hue;
    } hsv_t;

    class hsv_scoreboard;
        hsv_t expected_hsv[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function hsv_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int               hi;
            int               lo;
            int               delta;
            int               diff;
            int               base;
            int               hue;
            rth_pkg::sector_t sec;
            hsv_t             res;
            hi = int'(r);
            if (int'(g) > hi) hi = int'(g);
            if (int'(b) > hi) hi = int'(b);
            lo = int'(r);
            if (int'(g) < lo) lo = int'(g);
            if (int'(b) < lo) lo = int'(b);
            delta = hi - lo;
            res.val = hi[7:0];
            res.sat = 8'd0;
            res.hue = 8'd0;
            if (delta != 0) begin
                res.sat = 8'((255 * delta) / hi);
                if (hi == int'(r)) sec = rth_pkg::SEC_RED;
                else if (hi == int'(g)) sec = rth_pkg::SEC_GREEN;
                else sec = rth_pkg::SEC_BLUE;
                case (sec)
                    rth_pkg::SEC_RED: begin
                        base = 0;
                        diff = int'(g) - int'(b);
                    end
                    rth_pkg::SEC_GREEN: begin
                        base = int'(rth_pkg::GREEN_BASE);
                        diff = int'(b) - int'(r);
                    end
                    default: begin
                        base = int'(rth_pkg::BLUE_BASE);
                        diff = int'(r) - int'(g);
                    end
                endcase
                // Signed integer division truncates toward zero; negative hues wrap.
                hue = base + (int'(rth_pkg::HUE_SPAN) * diff) / delta;
                res.hue = hue[7:0];
            end
            return res;
        endfunction

        function void note_pixel(logic [23:0] px);
            expected_hsv.push_back(convert_pixel(px[7:0], px[15:8], px[23:16]));
        endfunction

        function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_pixel(logic [23:0] data);
            hsv_t exp_hsv;
            hsv_t act_hsv;
            act_hsv = data;
            if (expected_hsv.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected nothing, got 0x%06h", $time, data);
            end else begin
                exp_hsv = expected_hsv.pop_front();
                compare_field("hue", exp_hsv.hue, act_hsv.hue);
                compare_field("sat", exp_hsv.sat, act_hsv.sat);
                compare_field("val", exp_hsv.val, act_hsv.val);
            end
        endfunction

        function int pending_count();
            return expected_hsv.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = 24'd0;   // red_in, green_in, blue_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // hue_out, sat_out, val_out

    hsv_scoreboard board = new();
    int src_idle_pct  = 11;
    int sink_idle_pct = 58;
    int idle_cycles   = 0;

    rgb_to_hsv_8bit_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [23:0] rgb(int r, int g, int b);
        return {b[7:0], g[7:0], r[7:0]};
    endfunction

    function automatic logic [23:0] random_pixel();
        int kind;
        int hi;
        int lo;
        int r;
        int g;
        int b;
        kind = $urandom_range(0, 9);
        case (kind)
            6: begin
                hi = $urandom_range(0, 255);
                return rgb(hi, hi, hi);
            end
            7: begin
                hi = $urandom_range(1, 255);
                lo = $urandom_range(0, hi);
                case ($urandom_range(0, 2))
                    0: return rgb(hi, hi, lo);
                    1: return rgb(lo, hi, hi);
                    default: return rgb(hi, lo, hi);
                endcase
            end
            8: begin
                r = $urandom_range(2, 255);
                b = $urandom_range(1, r);
                g = $urandom_range(0, b - 1);
                return rgb(r, g, b);
            end
            9: return rgb($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic push_pixel(logic [23:0] px);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (s_tready !== 1'b1);
        board.note_pixel(px);
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid === 1'b1 && m_tready)
                board.check_pixel(m_tdata);
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_CYCLES) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        push_pixel(rgb(0, 0, 0));
        push_pixel(rgb(255, 255, 255));
        push_pixel(rgb(128, 128, 128));
        push_pixel(rgb(255, 0, 0));
        push_pixel(rgb(0, 255, 0));
        push_pixel(rgb(0, 0, 255));
        push_pixel(rgb(255, 255, 0));
        push_pixel(rgb(0, 255, 255));
        push_pixel(rgb(255, 0, 255));
        push_pixel(rgb(200, 10, 100));
        push_pixel(rgb(255, 1, 0));
        push_pixel(rgb(1, 0, 0));
        push_pixel(rgb(255, 254, 0));
        push_pixel(rgb(0, 1, 255));
        push_pixel(rgb(10, 255, 200));
        push_pixel(rgb(255, 128, 1));
        push_pixel(rgb(1, 2, 3));
        push_pixel(rgb(3, 2, 1));
        push_pixel(rgb(128, 0, 64));
        push_pixel(rgb(64, 200, 255));
        push_pixel(rgb(254, 255, 0));

        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            if (i == RANDOM_PIXELS / 3) begin
                src_idle_pct  = 58;
                sink_idle_pct = 11;
            end else if (i == 2 * RANDOM_PIXELS / 3) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            push_pixel(random_pixel());
        end
        s_tvalid <= 1'b0;

        while (board.pending_count() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
